### sv/lsm_pkg.sv
// lsm_pkg: shared constants, types and controller codes for line_segment_merge
// no dependencies; imported by the controller, the datapath and the top level

package lsm_pkg;

    // capacity of the line store, never more than one set's worth of results
    localparam int MAX_LINES    = 32;
    localparam int RESULT_LIMIT = 32;
    localparam int CAPACITY     = (MAX_LINES < RESULT_LIMIT) ? MAX_LINES : RESULT_LIMIT;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // field widths
    localparam int COORD_W = 16;
    localparam int TOL_W   = 15;
    localparam int DATA_W  = 5 * COORD_W;
    localparam int USER_W  = 2;

    localparam logic [TOL_W-1:0] TOL_RESET = 15'd480;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t slope;
    } line_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PICK,
        ST_BASE,
        ST_SCAN,
        ST_EMIT
    } lsm_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic merge_init;
        logic finish;
        logic i_next;
        logic base_rd;
        logic base_cap;
        logic scan;
        logic emit;
    } lsm_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic i_end;
        logic i_visited;
        logic scan_done;
        logic out_free;
    } lsm_status_t;

endpackage

### sv/lsm_ctrl.sv
// lsm_ctrl: sequencer for loading a set and walking the greedy merge
// depends on lsm_pkg; drives lsm_datapath through lsm_cmd_t

module lsm_ctrl
    import lsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  lsm_status_t status,
    output lsm_cmd_t    cmd,
    output lsm_state_t  state
);

    lsm_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.merge_init = 1'b1;
                        state_next     = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                priority if (status.i_end) begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end else if (status.i_visited) begin
                    cmd.i_next = 1'b1;
                end else begin
                    cmd.base_rd = 1'b1;
                    state_next  = ST_BASE;
                end
            end
            ST_BASE: begin
                cmd.base_cap = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_PICK;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign state = state_reg;

endmodule

### sv/lsm_datapath.sv
// lsm_datapath: line store, visited flags, closeness compare, averaging and output register
// depends on lsm_pkg; commanded by lsm_ctrl

module lsm_datapath
    import lsm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lsm_cmd_t          cmd,
    output lsm_status_t       status,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TOL_W-1:0]  cfg_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [USER_W-1:0] m_tuser,
    output logic              m_tlast
);

    // strict closeness of one coordinate pair, difference kept at full precision
    function automatic logic coord_close(coord_t a, coord_t b, logic [TOL_W-1:0] tol);
        logic signed [COORD_W+1:0] d;
        logic signed [COORD_W+1:0] t;
        d = {{2{a[COORD_W-1]}}, a} - {{2{b[COORD_W-1]}}, b};
        t = {3'b000, tol};
        return (d < t) && (d > -t);
    endfunction

    // floor of the mean of two fields
    function automatic coord_t floor_avg(coord_t a, coord_t b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    line_t                 mem [CAPACITY];
    line_t                 in_line;
    line_t                 rd_reg, base_reg, match_reg, res_line;
    logic [TOL_W-1:0]      tol_reg;
    logic [CNT_W-1:0]      count_reg, i_reg, j_reg;
    logic                  ovf_reg;
    logic [CAPACITY-1:0]   visited_reg;
    logic                  cmp_valid_reg;
    logic [IDX_W-1:0]      cmp_j_reg;
    logic                  found_reg;
    logic                  full;
    logic                  j_live;
    logic                  cmp_hit;
    logic [CAPACITY-1:0]   rem_vec;
    logic                  is_last;
    logic                  m_tvalid_reg;
    logic [DATA_W-1:0]     m_tdata_reg;
    logic [USER_W-1:0]     m_tuser_reg;
    logic                  m_tlast_reg;

    // unpack the incoming transaction, first field lowest
    assign in_line.sx    = s_tdata[15:0];
    assign in_line.sy    = s_tdata[31:16];
    assign in_line.ex    = s_tdata[47:32];
    assign in_line.ey    = s_tdata[63:48];
    assign in_line.slope = s_tdata[79:64];

    assign full   = (count_reg >= CNT_W'(CAPACITY));
    assign j_live = (j_reg < count_reg);

    // tolerance register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // line store write
    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            mem[count_reg[IDX_W-1:0]] <= in_line;
        end
    end

    // line store read, one port with registered data
    always_ff @(posedge aclk) begin
        if (cmd.base_rd) begin
            rd_reg <= mem[i_reg[IDX_W-1:0]];
        end else if (cmd.scan && j_live) begin
            rd_reg <= mem[j_reg[IDX_W-1:0]];
        end
    end

    // compare of the candidate just read against the base line
    assign cmp_hit = cmp_valid_reg && !visited_reg[cmp_j_reg]
                   && coord_close(base_reg.sx, rd_reg.sx, tol_reg)
                   && coord_close(base_reg.sy, rd_reg.sy, tol_reg)
                   && coord_close(base_reg.ex, rd_reg.ex, tol_reg)
                   && coord_close(base_reg.ey, rd_reg.ey, tol_reg);

    // fill count and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.finish) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.load) begin
            if (full) begin
                ovf_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // visited flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
        end else if (cmd.merge_init) begin
            visited_reg <= '0;
        end else begin
            if (cmd.base_rd) begin
                visited_reg[i_reg[IDX_W-1:0]] <= 1'b1;
            end
            if (cmd.scan && cmp_hit) begin
                visited_reg[cmp_j_reg] <= 1'b1;
            end
        end
    end

    // outer and inner indices, compare stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg         <= '0;
            j_reg         <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_j_reg     <= '0;
        end else begin
            if (cmd.merge_init) begin
                i_reg <= '0;
            end else if (cmd.i_next || cmd.emit) begin
                i_reg <= i_reg + CNT_W'(1);
            end
            if (cmd.base_cap) begin
                j_reg         <= i_reg + CNT_W'(1);
                cmp_valid_reg <= 1'b0;
            end else if (cmd.scan) begin
                cmp_valid_reg <= j_live;
                cmp_j_reg     <= j_reg[IDX_W-1:0];
                if (j_live) begin
                    j_reg <= j_reg + CNT_W'(1);
                end
            end
        end
    end

    // base line and last match
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.base_cap) begin
            found_reg <= 1'b0;
        end else if (cmd.scan && cmp_hit) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.base_cap) begin
            base_reg <= rd_reg;
        end
        if (cmd.scan && cmp_hit) begin
            match_reg <= rd_reg;
        end
    end

    // lines still to be emitted after this one
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            rem_vec[k] = !visited_reg[k] && (CNT_W'(k) > i_reg) && (CNT_W'(k) < count_reg);
        end
    end
    assign is_last = ~|rem_vec;

    // result line
    always_comb begin
        if (found_reg) begin
            res_line.sx    = floor_avg(base_reg.sx, match_reg.sx);
            res_line.sy    = floor_avg(base_reg.sy, match_reg.sy);
            res_line.ex    = floor_avg(base_reg.ex, match_reg.ex);
            res_line.ey    = floor_avg(base_reg.ey, match_reg.ey);
            res_line.slope = floor_avg(base_reg.slope, match_reg.slope);
        end else begin
            res_line = base_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {res_line.slope, res_line.ey, res_line.ex, res_line.sy, res_line.sx};
            m_tuser_reg <= {ovf_reg, found_reg};
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // status back to the controller
    assign status.i_end     = (i_reg == count_reg);
    assign status.i_visited = visited_reg[i_reg[IDX_W-1:0]];
    assign status.scan_done = !j_live && !cmp_valid_reg;
    assign status.out_free  = !m_tvalid_reg || m_tready;

endmodule

### sv/line_segment_merge.sv
// line_segment_merge: top level joining the controller and the datapath
// depends on lsm_pkg, lsm_ctrl and lsm_datapath

// Line records are loaded one per transaction into a 32-entry store until a
// transaction with s_tlast set; lines past 32 are dropped and flagged in
// m_tuser[1]. The block then stops taking input and merges: every line still
// unvisited is read, compared against each later line in the store at one line
// per cycle through the single read port of the store, and emitted through an
// output register, waiting while the sink stalls; lines absorbed into an
// earlier one are stepped past without being read. m_tlast marks the final
// result of a set, and input is taken again once the merge has stepped past
// every line in the store. The tolerance write channel is always ready; write
// it only while the block is waiting for input. The store needs no clearing
// pass after reset.

module line_segment_merge
    import lsm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // start_x, start_y, end_x, end_y, line_slope from the lowest bit up
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              s_tvalid,
    output logic              s_tready,
    // overlap_tolerance
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TOL_W-1:0]  cfg_data,
    // out_start_x, out_start_y, out_end_x, out_end_y, out_slope from the lowest bit up
    output logic [DATA_W-1:0] m_tdata,
    // was_merged, overflowed from the lowest bit up
    output logic [USER_W-1:0] m_tuser,
    output logic              m_tlast,
    output logic              m_tvalid,
    input  logic              m_tready
);

    lsm_cmd_t    cmd;
    lsm_status_t status;
    lsm_state_t  state;

    lsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    lsm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTH
    // a result is never written over one the sink has not taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // the final line of a set closes the input until the merge is done
    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken during merge");

    // once every line is handled the block takes input again
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_PICK && status.i_end) |=> (s_tready && state == ST_LOAD))
        else $error("merge did not return to loading");

    // a line is only read as base when it has not been visited
    a_base_unvisited: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.base_rd |-> (!status.i_visited && !status.i_end))
        else $error("visited line picked as base");
`endif

endmodule
